// File: design/bwu_pkg.sv
// ----------------------------------------------------------------------------
// bwu_pkg
// Shared types and constants of the breakpoint and watchpoint unit.
// ----------------------------------------------------------------------------
package bwu_pkg;

  // Command codes on the request channel
  localparam logic [3:0] CMD_BPADD       = 4'd0;
  localparam logic [3:0] CMD_BPDEL       = 4'd1;
  localparam logic [3:0] CMD_BPCLEAR     = 4'd2;
  localparam logic [3:0] CMD_BPLIST      = 4'd3;
  localparam logic [3:0] CMD_WPADD       = 4'd4;
  localparam logic [3:0] CMD_WPDEL       = 4'd5;
  localparam logic [3:0] CMD_WPLIST      = 4'd6;
  localparam logic [3:0] CMD_EXEC        = 4'd7;
  localparam logic [3:0] CMD_WRITE       = 4'd8;
  localparam logic [3:0] CMD_PAUSE       = 4'd9;
  localparam logic [3:0] CMD_RESUME      = 4'd10;
  localparam logic [3:0] CMD_FORCERESUME = 4'd11;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Stop reasons
  localparam logic [1:0] REASON_NONE  = 2'd0;
  localparam logic [1:0] REASON_PAUSE = 2'd1;
  localparam logic [1:0] REASON_BP    = 2'd2;
  localparam logic [1:0] REASON_WP    = 2'd3;

  // Watch length used when a zero length is given
  localparam logic [31:0] WATCH_LEN_DEFAULT = 32'd4;

  // List output limit
  localparam int unsigned   MAX_OUT   = 32;
  localparam int unsigned   CNT_W     = $clog2(MAX_OUT);
  localparam logic [CNT_W-1:0] LIST_LAST = CNT_W'(MAX_OUT - 1);

  // Command queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // Decoded operation
  typedef enum logic [3:0] {
    OP_BPADD,
    OP_BPDEL,
    OP_BPCLEAR,
    OP_BPLIST,
    OP_WPADD,
    OP_WPDEL,
    OP_WPLIST,
    OP_EXEC,
    OP_WRITE,
    OP_PAUSE,
    OP_RESUME,
    OP_FORCERESUME,
    OP_NOP
  } op_t;

  // Back end sequencer state
  typedef enum logic {
    BK_IDLE,
    BK_LIST
  } bk_state_t;

  // Queued, classified command
  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [31:0] len;
    logic [15:0] id;
    logic [31:0] value;
    logic [31:0] pc;
  } q_item_t;

  // Last stop record
  typedef struct packed {
    logic [1:0]  reason;
    logic [15:0] id;
    logic [31:0] addr;
    logic [31:0] value;
    logic [31:0] pc;
  } stop_rec_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] entry_id;
    logic        hit;
    logic        stopped;
    stop_rec_t   rec;
    logic [31:0] entry_addr;
    logic [31:0] entry_len;
    logic        last;
  } result_t;

  // Queue handshake between two modules
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// File: design/bwu_if.sv
// ----------------------------------------------------------------------------
// bwu_if
// Request and response channel interfaces of the breakpoint/watchpoint unit.
// ----------------------------------------------------------------------------
interface bwu_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [31:0] addr;
  logic [31:0] len;
  logic [15:0] id;
  logic [31:0] value;
  logic [31:0] pc;

  modport source (output valid, cmd, addr, len, id, value, pc, input ready);
  modport sink   (input valid, cmd, addr, len, id, value, pc, output ready);
endinterface

interface bwu_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] entry_id;
  logic        hit;
  logic        stopped;
  logic [1:0]  stop_reason;
  logic [15:0] stop_id;
  logic [31:0] stop_addr;
  logic [31:0] stop_value;
  logic [31:0] stop_pc;
  logic [31:0] entry_addr;
  logic [31:0] entry_len;
  logic        last;

  modport source (output valid, status, entry_id, hit, stopped, stop_reason, stop_id,
                  stop_addr, stop_value, stop_pc, entry_addr, entry_len, last,
                  input ready);
  modport sink   (input valid, status, entry_id, hit, stopped, stop_reason, stop_id,
                  stop_addr, stop_value, stop_pc, entry_addr, entry_len, last,
                  output ready);
endinterface

// File: design/bwu_front.sv
// ----------------------------------------------------------------------------
// bwu_front
// Accepts request transactions, decodes the command and normalizes the
// watch length before the item enters the command queue.
// ----------------------------------------------------------------------------
module bwu_front (
  bwu_req_if.sink          req,
  input  logic             q_full,
  output logic             push,
  output bwu_pkg::q_item_t item
);

  bwu_pkg::op_t op;

  // Accept whenever the queue has room
  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  // Decode command code, unused codes become a no-op
  always_comb begin
    unique case (req.cmd)
      bwu_pkg::CMD_BPADD:       op = bwu_pkg::OP_BPADD;
      bwu_pkg::CMD_BPDEL:       op = bwu_pkg::OP_BPDEL;
      bwu_pkg::CMD_BPCLEAR:     op = bwu_pkg::OP_BPCLEAR;
      bwu_pkg::CMD_BPLIST:      op = bwu_pkg::OP_BPLIST;
      bwu_pkg::CMD_WPADD:       op = bwu_pkg::OP_WPADD;
      bwu_pkg::CMD_WPDEL:       op = bwu_pkg::OP_WPDEL;
      bwu_pkg::CMD_WPLIST:      op = bwu_pkg::OP_WPLIST;
      bwu_pkg::CMD_EXEC:        op = bwu_pkg::OP_EXEC;
      bwu_pkg::CMD_WRITE:       op = bwu_pkg::OP_WRITE;
      bwu_pkg::CMD_PAUSE:       op = bwu_pkg::OP_PAUSE;
      bwu_pkg::CMD_RESUME:      op = bwu_pkg::OP_RESUME;
      bwu_pkg::CMD_FORCERESUME: op = bwu_pkg::OP_FORCERESUME;
      default:                  op = bwu_pkg::OP_NOP;
    endcase
  end

  // Pack the queue item; a zero watch length means one word
  always_comb begin
    item.op    = op;
    item.addr  = req.addr;
    item.len   = (req.len == 32'd0) ? bwu_pkg::WATCH_LEN_DEFAULT : req.len;
    item.id    = req.id;
    item.value = req.value;
    item.pc    = req.pc;
  end

endmodule

// File: design/bwu_fifo.sv
// ----------------------------------------------------------------------------
// bwu_fifo
// Small command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bwu_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bwu_pkg::q_item_t    item_in,
  input  logic                pop,
  output bwu_pkg::q_item_t    item_out,
  output bwu_pkg::q_status_t  stat
);

  bwu_pkg::q_item_t                mem [bwu_pkg::QDEPTH];
  logic [bwu_pkg::QPTR_W-1:0]      wptr;
  logic [bwu_pkg::QPTR_W-1:0]      rptr;
  logic [bwu_pkg::QPTR_W:0]        count;
  logic                            do_push;
  logic                            do_pop;

  assign stat.valid = (count != '0);
  assign stat.full  = (count == (bwu_pkg::QPTR_W+1)'(bwu_pkg::QDEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign item_out   = mem[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= item_in;
  end

endmodule

// File: design/bwu_back.sv
// ----------------------------------------------------------------------------
// bwu_back
// Executes queued commands: breakpoint and watchpoint tables with parallel
// comparators, id counter, stop record, list sequencer and result register.
// ----------------------------------------------------------------------------
module bwu_back #(
  parameter int unsigned BP_SLOTS = 32,
  parameter int unsigned WP_SLOTS = 8,
  parameter int unsigned ID_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  bwu_pkg::q_item_t   q,
  output logic               pop,
  bwu_rsp_if.source          rsp
);

  localparam int unsigned BP_IW  = (BP_SLOTS > 1) ? $clog2(BP_SLOTS) : 1;
  localparam int unsigned WP_IW  = (WP_SLOTS > 1) ? $clog2(WP_SLOTS) : 1;
  localparam int unsigned LIST_W = (BP_SLOTS > WP_SLOTS) ? BP_SLOTS : WP_SLOTS;
  localparam logic [ID_WIDTH-1:0] ID_ONE = {{(ID_WIDTH-1){1'b0}}, 1'b1};

  // Tables
  logic [BP_SLOTS-1:0] bp_used;
  logic [BP_SLOTS-1:0] bp_used_next;
  logic [31:0]         bp_addr  [BP_SLOTS];
  logic [ID_WIDTH-1:0] bp_ident [BP_SLOTS];
  logic [WP_SLOTS-1:0] wp_used;
  logic [WP_SLOTS-1:0] wp_used_next;
  logic [31:0]         wp_base  [WP_SLOTS];
  logic [31:0]         wp_len   [WP_SLOTS];
  logic [ID_WIDTH-1:0] wp_ident [WP_SLOTS];

  // Control state
  logic [ID_WIDTH-1:0]   next_ident;
  logic [ID_WIDTH-1:0]   next_ident_next;
  logic                  armed;
  logic                  armed_next;
  logic                  stop_flag;
  logic                  stop_flag_next;
  bwu_pkg::stop_rec_t    rec;
  bwu_pkg::stop_rec_t    rec_next;
  bwu_pkg::bk_state_t    state;
  bwu_pkg::bk_state_t    state_next;
  logic [LIST_W-1:0]     list_mask;
  logic [LIST_W-1:0]     list_mask_next;
  logic [bwu_pkg::CNT_W-1:0] list_cnt;
  logic [bwu_pkg::CNT_W-1:0] list_cnt_next;
  logic                  list_wp;
  logic                  list_wp_next;

  // Result register
  logic                  rsp_valid;
  bwu_pkg::result_t      res_q;
  bwu_pkg::result_t      res;
  logic                  load_res;
  logic                  can_load;

  // Datapath strobes
  logic                  exec_go;
  logic                  bp_set;
  logic                  wp_set;
  logic                  is_list;
  logic [LIST_W-1:0]     list_start_mask;
  logic [LIST_W-1:0]     list_rest;
  logic                  list_done;
  logic [ID_WIDTH-1:0]   id_inc;
  logic [ID_WIDTH-1:0]   id_wrap;

  // Comparator results
  logic                  bp_free_found;
  logic [BP_IW-1:0]      bp_free_idx;
  logic                  wp_free_found;
  logic [WP_IW-1:0]      wp_free_idx;
  logic [BP_SLOTS-1:0]   bp_del_hit;
  logic [WP_SLOTS-1:0]   wp_del_hit;
  logic                  bp_match_found;
  logic [BP_IW-1:0]      bp_match_idx;
  logic                  wp_match_found;
  logic [WP_IW-1:0]      wp_match_idx;
  logic [BP_IW-1:0]      bp_pick_idx;
  logic [WP_IW-1:0]      wp_pick_idx;
  logic [31:0]           wp_diff [WP_SLOTS];

  assign can_load = !rsp_valid || rsp.ready;
  assign exec_go  = (state == bwu_pkg::BK_IDLE) && q_valid && can_load;
  assign pop      = exec_go;
  assign is_list  = (q.op == bwu_pkg::OP_BPLIST) || (q.op == bwu_pkg::OP_WPLIST);

  // Next id: wrap within the id width and skip zero
  assign id_inc  = next_ident + ID_ONE;
  assign id_wrap = (id_inc == '0) ? ID_ONE : id_inc;

  // Free slot search, lowest index wins
  always_comb begin
    bp_free_found = 1'b0;
    bp_free_idx   = '0;
    for (int i = BP_SLOTS - 1; i >= 0; i--) begin
      if (!bp_used[i]) begin
        bp_free_found = 1'b1;
        bp_free_idx   = BP_IW'(i);
      end
    end
    wp_free_found = 1'b0;
    wp_free_idx   = '0;
    for (int i = WP_SLOTS - 1; i >= 0; i--) begin
      if (!wp_used[i]) begin
        wp_free_found = 1'b1;
        wp_free_idx   = WP_IW'(i);
      end
    end
  end

  // Id compare for delete
  always_comb begin
    for (int i = 0; i < BP_SLOTS; i++) begin
      bp_del_hit[i] = bp_used[i] && (32'(bp_ident[i]) == 32'(q.id));
    end
    for (int i = 0; i < WP_SLOTS; i++) begin
      wp_del_hit[i] = wp_used[i] && (32'(wp_ident[i]) == 32'(q.id));
    end
  end

  // Breakpoint address compare, lowest matching slot wins
  always_comb begin
    bp_match_found = 1'b0;
    bp_match_idx   = '0;
    for (int i = BP_SLOTS - 1; i >= 0; i--) begin
      if (bp_used[i] && (bp_addr[i] == q.addr)) begin
        bp_match_found = 1'b1;
        bp_match_idx   = BP_IW'(i);
      end
    end
  end

  // Watch range compare: offset from base below length
  always_comb begin
    wp_match_found = 1'b0;
    wp_match_idx   = '0;
    for (int i = WP_SLOTS - 1; i >= 0; i--) begin
      wp_diff[i] = q.addr - wp_base[i];
      if (wp_used[i] && (wp_diff[i] < wp_len[i])) begin
        wp_match_found = 1'b1;
        wp_match_idx   = WP_IW'(i);
      end
    end
  end

  // List sequencer: pick lowest remaining slot
  always_comb begin
    bp_pick_idx = '0;
    for (int i = BP_SLOTS - 1; i >= 0; i--) begin
      if (list_mask[i]) bp_pick_idx = BP_IW'(i);
    end
    wp_pick_idx = '0;
    for (int i = WP_SLOTS - 1; i >= 0; i--) begin
      if (list_mask[i]) wp_pick_idx = WP_IW'(i);
    end
  end

  assign list_start_mask = (q.op == bwu_pkg::OP_WPLIST) ? LIST_W'(wp_used) : LIST_W'(bp_used);
  assign list_rest       = list_mask & (list_mask - 1'b1);
  assign list_done       = (list_rest == '0) || (list_cnt == bwu_pkg::LIST_LAST);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bwu_pkg::BK_IDLE: begin
        if (exec_go && is_list && (list_start_mask != '0)) state_next = bwu_pkg::BK_LIST;
      end
      bwu_pkg::BK_LIST: begin
        if (can_load && list_done) state_next = bwu_pkg::BK_IDLE;
      end
      default: state_next = bwu_pkg::BK_IDLE;
    endcase
  end

  // Command execution and result forming
  always_comb begin
    armed_next      = armed;
    stop_flag_next  = stop_flag;
    rec_next        = rec;
    next_ident_next = next_ident;
    bp_used_next    = bp_used;
    wp_used_next    = wp_used;
    bp_set          = 1'b0;
    wp_set          = 1'b0;
    list_mask_next  = list_mask;
    list_cnt_next   = list_cnt;
    list_wp_next    = list_wp;
    load_res        = 1'b0;
    res             = '0;
    res.status      = bwu_pkg::ST_OK;
    res.last        = 1'b1;

    unique case (state)
      bwu_pkg::BK_IDLE: begin
        if (exec_go) begin
          load_res = 1'b1;
          unique case (q.op)
            bwu_pkg::OP_BPADD: begin
              if (bp_free_found) begin
                bp_set                    = 1'b1;
                bp_used_next[bp_free_idx] = 1'b1;
                next_ident_next           = id_wrap;
                armed_next                = 1'b1;
                if (!stop_flag) rec_next.reason = bwu_pkg::REASON_NONE;
                res.entry_id   = 16'(32'(next_ident));
                res.entry_addr = q.addr;
              end else begin
                res.status = bwu_pkg::ST_FULL;
              end
            end
            bwu_pkg::OP_WPADD: begin
              if (wp_free_found) begin
                wp_set                    = 1'b1;
                wp_used_next[wp_free_idx] = 1'b1;
                next_ident_next           = id_wrap;
                armed_next                = 1'b1;
                if (!stop_flag) rec_next.reason = bwu_pkg::REASON_NONE;
                res.entry_id   = 16'(32'(next_ident));
                res.entry_addr = q.addr;
                res.entry_len  = q.len;
              end else begin
                res.status = bwu_pkg::ST_FULL;
              end
            end
            bwu_pkg::OP_BPDEL: begin
              bp_used_next = bp_used & ~bp_del_hit;
              if (bp_del_hit != '0) begin
                armed_next = 1'b1;
                if (!stop_flag) rec_next.reason = bwu_pkg::REASON_NONE;
              end else begin
                res.status = bwu_pkg::ST_NOT_FOUND;
              end
            end
            bwu_pkg::OP_WPDEL: begin
              wp_used_next = wp_used & ~wp_del_hit;
              if (wp_del_hit != '0) begin
                armed_next = 1'b1;
                if (!stop_flag) rec_next.reason = bwu_pkg::REASON_NONE;
              end else begin
                res.status = bwu_pkg::ST_NOT_FOUND;
              end
            end
            bwu_pkg::OP_BPCLEAR: begin
              bp_used_next = '0;
              armed_next   = 1'b1;
              if (!stop_flag) rec_next.reason = bwu_pkg::REASON_NONE;
            end
            bwu_pkg::OP_BPLIST, bwu_pkg::OP_WPLIST: begin
              if (list_start_mask == '0) begin
                res.status = bwu_pkg::ST_EMPTY;
              end else begin
                load_res       = 1'b0;
                list_mask_next = list_start_mask;
                list_cnt_next  = '0;
                list_wp_next   = (q.op == bwu_pkg::OP_WPLIST);
              end
            end
            bwu_pkg::OP_EXEC: begin
              if (armed && bp_match_found) begin
                stop_flag_next = 1'b1;
                rec_next.reason = bwu_pkg::REASON_BP;
                rec_next.id     = 16'(32'(bp_ident[bp_match_idx]));
                rec_next.addr   = q.addr;
                rec_next.value  = 32'd0;
                rec_next.pc     = q.addr;
                res.hit         = 1'b1;
              end
            end
            bwu_pkg::OP_WRITE: begin
              if (armed && wp_match_found) begin
                stop_flag_next = 1'b1;
                rec_next.reason = bwu_pkg::REASON_WP;
                rec_next.id     = 16'(32'(wp_ident[wp_match_idx]));
                rec_next.addr   = q.addr;
                rec_next.value  = q.value;
                rec_next.pc     = q.pc;
                res.hit         = 1'b1;
              end
            end
            bwu_pkg::OP_PAUSE: begin
              armed_next     = 1'b1;
              if (!stop_flag) rec_next.reason = bwu_pkg::REASON_PAUSE;
              stop_flag_next = 1'b1;
            end
            bwu_pkg::OP_RESUME: begin
              stop_flag_next  = 1'b0;
              rec_next.reason = bwu_pkg::REASON_NONE;
            end
            bwu_pkg::OP_FORCERESUME: begin
              stop_flag_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
      bwu_pkg::BK_LIST: begin
        if (can_load) begin
          load_res       = 1'b1;
          list_mask_next = list_rest;
          list_cnt_next  = list_cnt + 1'b1;
          res.last       = list_done;
          if (list_wp) begin
            res.entry_id   = 16'(32'(wp_ident[wp_pick_idx]));
            res.entry_addr = wp_base[wp_pick_idx];
            res.entry_len  = wp_len[wp_pick_idx];
          end else begin
            res.entry_id   = 16'(32'(bp_ident[bp_pick_idx]));
            res.entry_addr = bp_addr[bp_pick_idx];
          end
        end
      end
      default: ;
    endcase

    res.stopped = stop_flag_next;
    res.rec     = rec_next;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bwu_pkg::BK_IDLE;
      bp_used    <= '0;
      wp_used    <= '0;
      next_ident <= ID_ONE;
      armed      <= 1'b0;
      stop_flag  <= 1'b0;
      rec        <= '0;
      list_mask  <= '0;
      list_cnt   <= '0;
      list_wp    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      bp_used    <= bp_used_next;
      wp_used    <= wp_used_next;
      next_ident <= next_ident_next;
      armed      <= armed_next;
      stop_flag  <= stop_flag_next;
      rec        <= rec_next;
      list_mask  <= list_mask_next;
      list_cnt   <= list_cnt_next;
      list_wp    <= list_wp_next;
      if (can_load) rsp_valid <= load_res;
    end
  end

  // Table payload and result payload
  always_ff @(posedge clk) begin
    if (bp_set) begin
      bp_addr[bp_free_idx]  <= q.addr;
      bp_ident[bp_free_idx] <= next_ident;
    end
    if (wp_set) begin
      wp_base[wp_free_idx]  <= q.addr;
      wp_len[wp_free_idx]   <= q.len;
      wp_ident[wp_free_idx] <= next_ident;
    end
    if (can_load && load_res) res_q <= res;
  end

  // Drive the response channel
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = res_q.status;
  assign rsp.entry_id    = res_q.entry_id;
  assign rsp.hit         = res_q.hit;
  assign rsp.stopped     = res_q.stopped;
  assign rsp.stop_reason = res_q.rec.reason;
  assign rsp.stop_id     = res_q.rec.id;
  assign rsp.stop_addr   = res_q.rec.addr;
  assign rsp.stop_value  = res_q.rec.value;
  assign rsp.stop_pc     = res_q.rec.pc;
  assign rsp.entry_addr  = res_q.entry_addr;
  assign rsp.entry_len   = res_q.entry_len;
  assign rsp.last        = res_q.last;

endmodule

// File: design/breakpoint_watchpoint_unit_top.sv
// ----------------------------------------------------------------------------
// breakpoint_watchpoint_unit_top
// A request is first stored in the command queue; the back end then executes it
// and registers its result in the result register once that register is free.
// Single-result commands run at one request per cycle while the response channel
// is ready; a list first loads the list sequencer, then returns one entry per result.
// Reset (synchronous): tables empty, id counter at one, unarmed, not stopped.
// ----------------------------------------------------------------------------
module breakpoint_watchpoint_unit_top #(
  parameter int unsigned BP_SLOTS = 32,
  parameter int unsigned WP_SLOTS = 8,
  parameter int unsigned ID_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  bwu_req_if.sink    req,
  bwu_rsp_if.source  rsp
);

  logic                q_push;
  logic                q_pop;
  bwu_pkg::q_item_t    q_in;
  bwu_pkg::q_item_t    q_out;
  bwu_pkg::q_status_t  q_stat;

  // Decode requests into the queue
  bwu_front u_front (
    .req    (req),
    .q_full (q_stat.full),
    .push   (q_push),
    .item   (q_in)
  );

  // Decouple front and back
  bwu_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .pop      (q_pop),
    .item_out (q_out),
    .stat     (q_stat)
  );

  // Execute commands
  bwu_back #(
    .BP_SLOTS (BP_SLOTS),
    .WP_SLOTS (WP_SLOTS),
    .ID_WIDTH (ID_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_stat.valid),
    .q       (q_out),
    .pop     (q_pop),
    .rsp     (rsp)
  );

endmodule
